[src/spd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants, the result beat type and the checksum step for the
// serial packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

    // Line codes
    localparam logic [7:0] SYNC_BYTE = 8'hE0;
    localparam logic [7:0] ESC_BYTE  = 8'hD0;
    localparam logic [7:0] ESC_SYNC  = 8'hDF;
    localparam logic [7:0] ESC_ESC   = 8'hCF;
    localparam logic [7:0] BROADCAST = 8'hFF;

    localparam int unsigned INDEX_W = 9;
    localparam int unsigned TDATA_W = 24;
    localparam int unsigned TUSER_W = 2;

    // One decoded byte with its position and end-of-packet verdicts
    typedef struct packed {
        logic [7:0]         packet_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               is_last;
        logic               addressed_here;
        logic               sum_good;
    } t_result;

    // Running checksum step: sync and escape codes add 0xD0 + byte - 1
    function automatic logic [7:0] sum_add(input logic [7:0] sum, input logic [7:0] b);
        logic [7:0] addend;
        begin
            if (b == SYNC_BYTE || b == ESC_BYTE) begin
                addend = ESC_BYTE + b - 8'd1;
            end else begin
                addend = b;
            end
            sum_add = sum + addend;
        end
    endfunction

endpackage

[src/spd_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_deframer
// Sync search, escape removal, byte counting, address match and checksum.
// Produces at most one result per accepted raw byte in the same cycle.
// ----------------------------------------------------------------------------
module spd_deframer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_beat,          // raw byte accepted this cycle
    input  logic [7:0]       i_rx_byte,
    input  logic [7:0]       i_node_address,
    output logic             o_res_valid,
    output spd_pkg::t_result o_res
);
    import spd_pkg::*;

    logic                r_in_packet,  n_in_packet;
    logic                r_esc_pend,   n_esc_pend;
    logic [INDEX_W-1:0]  r_bytes_seen, n_bytes_seen;
    logic [7:0]          r_decl_size,  n_decl_size;
    logic                r_addr_hit,   n_addr_hit;
    logic [7:0]          r_sum,        n_sum;

    logic [7:0]          dec_byte;
    logic [INDEX_W-1:0]  last_index;
    logic                last;

    // Decode and state update
    always_comb begin
        n_in_packet  = r_in_packet;
        n_esc_pend   = r_esc_pend;
        n_bytes_seen = r_bytes_seen;
        n_decl_size  = r_decl_size;
        n_addr_hit   = r_addr_hit;
        n_sum        = r_sum;
        o_res_valid  = 1'b0;
        last         = 1'b0;
        last_index   = '0;

        // unescape
        if (r_esc_pend) begin
            if (i_rx_byte == ESC_SYNC) begin
                dec_byte = SYNC_BYTE;
            end else if (i_rx_byte == ESC_ESC) begin
                dec_byte = ESC_BYTE;
            end else begin
                dec_byte = i_rx_byte;
            end
        end else begin
            dec_byte = i_rx_byte;
        end

        if (i_beat) begin
            if (!r_in_packet) begin
                if (i_rx_byte == SYNC_BYTE) begin
                    n_in_packet  = 1'b1;
                    n_esc_pend   = 1'b0;
                    n_bytes_seen = '0;
                    n_decl_size  = '0;
                    n_addr_hit   = 1'b0;
                    n_sum        = '0;
                end
            end else if (!r_esc_pend && i_rx_byte == ESC_BYTE) begin
                n_esc_pend = 1'b1;
            end else begin
                n_esc_pend  = 1'b0;
                o_res_valid = 1'b1;
                if (r_bytes_seen == INDEX_W'(0)) begin
                    n_addr_hit = (dec_byte == BROADCAST) || (dec_byte == i_node_address);
                end
                if (r_bytes_seen == INDEX_W'(1)) begin
                    n_decl_size = dec_byte;
                end
                // size byte is decoded this very beat at index 1
                last_index = {1'b0, n_decl_size} + INDEX_W'(1);
                last = (r_bytes_seen != '0) && (r_bytes_seen == last_index);
                if (last) begin
                    n_in_packet  = 1'b0;
                    n_bytes_seen = '0;
                end else begin
                    n_sum        = sum_add(r_sum, dec_byte);
                    n_bytes_seen = r_bytes_seen + INDEX_W'(1);
                end
            end
        end

        o_res.packet_byte    = dec_byte;
        o_res.byte_index     = r_bytes_seen;
        o_res.is_last        = last;
        o_res.addressed_here = last && n_addr_hit;
        o_res.sum_good       = last && (r_sum == dec_byte);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet  <= 1'b0;
            r_esc_pend   <= 1'b0;
            r_bytes_seen <= '0;
            r_decl_size  <= '0;
            r_addr_hit   <= 1'b0;
            r_sum        <= '0;
        end else begin
            r_in_packet  <= n_in_packet;
            r_esc_pend   <= n_esc_pend;
            r_bytes_seen <= n_bytes_seen;
            r_decl_size  <= n_decl_size;
            r_addr_hit   <= n_addr_hit;
            r_sum        <= n_sum;
        end
    end

endmodule

[src/spd_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_out_buf
// Result register with a skid stage, so the input side can take one more beat
// while a finished result waits on the output.
// ----------------------------------------------------------------------------
module spd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  spd_pkg::t_result i_res,
    output logic             o_room,       // a push can be taken this cycle
    output logic             o_valid,
    input  logic             i_ready,
    output spd_pkg::t_result o_res
);
    import spd_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    pop;

    assign pop     = r_out_valid && i_ready;
    assign o_room  = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (pop) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push && r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else if (pop || !r_out_valid) begin
                r_out_valid <= i_push;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

endmodule

[src/serial_packet_deframer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_packet_deframer_unit
// Receive-side packet deframer: sync hunt, escape removal, byte indexing,
// address match and checksum check on the final byte.
// ----------------------------------------------------------------------------
// A decoded byte is held in the output buffer's result register before it appears on the output.
// Throughput: one raw beat per cycle while the skid stage is empty.
// A stalled output fills a one-beat skid stage before tready drops.
// Reset (synchronous, active low): idle and hunting for sync, buffers empty,
// node address 0xFF (broadcast only).
module serial_packet_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,     // node_address
    // raw byte stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,         // [7:0] rx_byte
    // decoded byte stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [spd_pkg::TDATA_W-1:0] o_m_tdata, // [7:0] packet_byte, [16:8] byte_index
    output logic        o_m_tlast,         // is_last
    output logic [spd_pkg::TUSER_W-1:0] o_m_tuser  // [0] addressed_here, [1] sum_good
);
    import spd_pkg::*;

    logic [7:0] r_node_address;
    logic       beat;
    logic       res_valid;
    t_result    res;
    t_result    out_res;
    logic       room;

    // Node address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_address <= BROADCAST;
        end else if (i_cfg_wr_en) begin
            r_node_address <= i_cfg_wr_data;
        end
    end

    assign o_s_tready = room;
    assign beat       = i_s_tvalid && room;

    spd_deframer u_deframer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_beat         (beat),
        .i_rx_byte      (i_s_tdata),
        .i_node_address (r_node_address),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    spd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_room  (room),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res)
    );

    // Output packing
    assign o_m_tdata = {7'd0, out_res.byte_index, out_res.packet_byte};
    assign o_m_tlast = out_res.is_last;
    assign o_m_tuser = {out_res.sum_good, out_res.addressed_here};

endmodule
